FILE: rtl/tlvcp_pkg.sv
`default_nettype none

package tlvcp_pkg;

    // Longest container accepted; byte counter saturates one above it
    localparam int unsigned MAX_CONTAINER_BYTES = 1048576;
    localparam int unsigned CNT_W               = $clog2(MAX_CONTAINER_BYTES + 2);

    localparam int unsigned HDR_BYTES  = 16;
    localparam logic [31:0] MAGIC_WORD = 32'h3156_4C54;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;

    // Container header byte positions that trigger checks or captures
    localparam logic [3:0] POS_MAGIC_END   = 4'd3;
    localparam logic [3:0] POS_VERDOM_END  = 4'd7;
    localparam logic [3:0] POS_SIZE_END    = 4'd11;
    localparam logic [3:0] POS_CHECK_END   = 4'd15;

    // Field header byte index
    localparam logic [1:0] FH_TAG_LO = 2'd0;
    localparam logic [1:0] FH_TAG_HI = 2'd1;
    localparam logic [1:0] FH_LEN_LO = 2'd2;
    localparam logic [1:0] FH_LEN_HI = 2'd3;

    typedef enum logic [1:0] {
        KIND_CONT_HDR  = 2'd0,
        KIND_FIELD_HDR = 2'd1,
        KIND_DATA      = 2'd2,
        KIND_IGNORED   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_TOO_LARGE = 4'd2,
        ST_MAGIC     = 4'd3,
        ST_VERSION   = 4'd4,
        ST_DOMAIN    = 4'd5,
        ST_SIZE      = 4'd6,
        ST_CRC       = 4'd7,
        ST_TRUNC_HDR = 4'd8,
        ST_ZERO_TAG  = 4'd9,
        ST_OVERRUN   = 4'd10
    } t_status;

    typedef enum logic [2:0] {
        PH_AWAIT  = 3'b001,
        PH_DATA   = 3'b010,
        PH_IGNORE = 3'b100
    } t_phase;

    // One byte of reflected CRC-32, bit at a time
    function automatic logic [31:0] crc32_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tlv_container_checker_parser_core.sv
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+-------------------------------------
// in       | input     | i_in_valid / o_in_stall  | i_in_byte, i_in_last
// out      | output    | o_out_valid / i_out_stall| o_byte_kind .. o_status
// cfg      | input     | i_cfg_we                 | i_cfg_data (expected domain)
//
// One item per cycle sustained while the output does not stall.
// An input register feeds the parser/CRC logic, which writes the result register
// and all parser state in the same cycle (CRC byte step is 8 unrolled XOR stages).
// While the result is stalled the input register still takes one more item.
// Sync active-low reset clears valid bits and parser state; CRC starts at all ones.
// After an item flagged last, all parser state returns to its reset value.

`default_nettype none

module tlv_container_checker_parser_core import tlvcp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_byte_kind,
    output logic [15:0]      o_field_tag,
    output logic [15:0]      o_field_length,
    output logic [15:0]      o_field_offset,
    output logic             o_field_begin,
    output logic             o_field_finish,
    output logic [7:0]       o_data_byte,
    output logic             o_done_res,
    output logic [3:0]       o_status
);

    // configuration register
    logic [15:0] r_expected_domain;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // parser state
    logic [CNT_W-1:0] r_byte_count,       n_byte_count;
    logic [31:0]      r_header_word,      n_header_word;
    logic [31:0]      r_payload_declared, n_payload_declared;
    logic [31:0]      r_stored_check,     n_stored_check;
    logic [31:0]      r_crc,              n_crc;
    t_phase           r_field_phase,      n_field_phase;
    logic [1:0]       r_hdr_idx,          n_hdr_idx;
    logic [15:0]      r_cur_tag,          n_cur_tag;
    logic [15:0]      r_cur_len,          n_cur_len;
    logic [15:0]      r_left,             n_left;
    logic [3:0]       r_first_error,      n_first_error;

    // result register
    logic        r_out_valid;
    t_kind       r_kind,   n_kind;
    logic [15:0] r_tag,    n_tag;
    logic [15:0] r_len,    n_len;
    logic [15:0] r_off,    n_off;
    logic        r_beg,    n_beg;
    logic        r_fin,    n_fin;
    logic [7:0]  r_data;
    logic        r_done;
    logic [3:0]  r_status, n_status;

    logic        adv;
    logic        in_hdr;
    logic [3:0]  err_body;
    logic [3:0]  err_last;

    // handshake: the input register moves on whenever the result register is free
    assign adv        = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_domain <= '0;
        end else if (i_cfg_we) begin
            r_expected_domain <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    assign in_hdr = (r_byte_count[CNT_W-1:4] == '0);

    // parser: next state and result for the item in the input register
    always_comb begin
        n_byte_count       = r_byte_count;
        n_header_word      = r_header_word;
        n_payload_declared = r_payload_declared;
        n_stored_check     = r_stored_check;
        n_crc              = r_crc;
        n_field_phase      = r_field_phase;
        n_hdr_idx          = r_hdr_idx;
        n_cur_tag          = r_cur_tag;
        n_cur_len          = r_cur_len;
        n_left             = r_left;
        err_body           = r_first_error;
        n_kind             = KIND_CONT_HDR;
        n_tag              = '0;
        n_len              = '0;
        n_off              = '0;
        n_beg              = 1'b0;
        n_fin              = 1'b0;

        if (in_hdr) begin
            // container header: shift in little-endian words
            n_header_word = {r_in_byte, r_header_word[31:8]};
            if (r_byte_count[3:0] == POS_MAGIC_END && n_header_word != MAGIC_WORD
                && err_body == ST_OK) begin
                err_body = ST_MAGIC;
            end
            if (r_byte_count[3:0] == POS_VERDOM_END && err_body == ST_OK) begin
                if (n_header_word[15:0] != 16'd1) begin
                    err_body = ST_VERSION;
                end else if (n_header_word[31:16] != r_expected_domain) begin
                    err_body = ST_DOMAIN;
                end
            end
            if (r_byte_count[3:0] == POS_SIZE_END) begin
                n_payload_declared = n_header_word;
            end
            if (r_byte_count[3:0] == POS_CHECK_END) begin
                n_stored_check = n_header_word;
            end
        end else begin
            n_crc = crc32_byte(r_crc, r_in_byte);
            case (r_field_phase)
                PH_IGNORE: begin
                    n_kind = KIND_IGNORED;
                end
                PH_AWAIT: begin
                    n_kind = KIND_FIELD_HDR;
                    case (r_hdr_idx)
                        FH_TAG_LO: n_cur_tag = {8'd0, r_in_byte};
                        FH_TAG_HI: n_cur_tag = {r_in_byte, r_cur_tag[7:0]};
                        FH_LEN_LO: n_cur_len = {8'd0, r_in_byte};
                        default:   n_cur_len = {r_in_byte, r_cur_len[7:0]};
                    endcase
                    if (r_hdr_idx == FH_LEN_HI) begin
                        n_hdr_idx = FH_TAG_LO;
                        if (n_cur_tag == '0) begin
                            n_field_phase = PH_IGNORE;
                            if (err_body == ST_OK) begin
                                err_body = ST_ZERO_TAG;
                            end
                        end else begin
                            n_tag = n_cur_tag;
                            n_len = n_cur_len;
                            n_beg = 1'b1;
                            if (n_cur_len == '0) begin
                                n_fin = 1'b1;
                            end else begin
                                n_field_phase = PH_DATA;
                                n_left        = n_cur_len;
                            end
                        end
                    end else begin
                        n_hdr_idx = r_hdr_idx + 2'd1;
                    end
                end
                default: begin
                    // field data
                    n_kind = KIND_DATA;
                    n_tag  = r_cur_tag;
                    n_len  = r_cur_len;
                    n_off  = r_cur_len - r_left;
                    n_left = r_left - 16'd1;
                    if (n_left == '0) begin
                        n_fin         = 1'b1;
                        n_field_phase = PH_AWAIT;
                    end
                end
            endcase
        end

        // saturating byte count
        if (r_byte_count <= CNT_W'(MAX_CONTAINER_BYTES)) begin
            n_byte_count = r_byte_count + CNT_W'(1);
        end

        // end-of-container field-walk errors
        err_last = err_body;
        if (!in_hdr && err_last == ST_OK) begin
            if (n_field_phase == PH_AWAIT && n_hdr_idx != FH_TAG_LO) begin
                err_last = ST_TRUNC_HDR;
            end else if (n_field_phase == PH_DATA) begin
                err_last = ST_OVERRUN;
            end
        end

        // verdict
        n_status      = err_body;
        n_first_error = err_body;
        if (r_in_last) begin
            if (n_byte_count < CNT_W'(HDR_BYTES)) begin
                n_status = ST_SHORT;
            end else if (n_byte_count > CNT_W'(MAX_CONTAINER_BYTES)) begin
                n_status = ST_TOO_LARGE;
            end else if (err_last == ST_MAGIC || err_last == ST_VERSION
                         || err_last == ST_DOMAIN) begin
                n_status = err_last;
            end else if (n_payload_declared != (32'(n_byte_count) - 32'(HDR_BYTES))) begin
                n_status = ST_SIZE;
            end else if (~n_crc != n_stored_check) begin
                n_status = ST_CRC;
            end else begin
                n_status = err_last;
            end
        end
    end

    // parser state; cleared after the last item of a container
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (adv && r_in_last)) begin
            r_byte_count       <= '0;
            r_header_word      <= '0;
            r_payload_declared <= '0;
            r_stored_check     <= '0;
            r_crc              <= CRC_INIT;
            r_field_phase      <= PH_AWAIT;
            r_hdr_idx          <= FH_TAG_LO;
            r_cur_tag          <= '0;
            r_cur_len          <= '0;
            r_left             <= '0;
            r_first_error      <= ST_OK;
        end else if (adv) begin
            r_byte_count       <= n_byte_count;
            r_header_word      <= n_header_word;
            r_payload_declared <= n_payload_declared;
            r_stored_check     <= n_stored_check;
            r_crc              <= n_crc;
            r_field_phase      <= n_field_phase;
            r_hdr_idx          <= n_hdr_idx;
            r_cur_tag          <= n_cur_tag;
            r_cur_len          <= n_cur_len;
            r_left             <= n_left;
            r_first_error      <= n_first_error;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (adv) begin
            r_kind   <= n_kind;
            r_tag    <= n_tag;
            r_len    <= n_len;
            r_off    <= n_off;
            r_beg    <= n_beg;
            r_fin    <= n_fin;
            r_data   <= r_in_byte;
            r_done   <= r_in_last;
            r_status <= n_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_kind    = r_kind;
    assign o_field_tag    = r_tag;
    assign o_field_length = r_len;
    assign o_field_offset = r_off;
    assign o_field_begin  = r_beg;
    assign o_field_finish = r_fin;
    assign o_data_byte    = r_data;
    assign o_done_res     = r_done;
    assign o_status       = r_status;

    // checks
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_field_phase))
        else $error("field phase not one-hot");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_last) |=> (r_byte_count == '0 && r_first_error == ST_OK))
        else $error("parser state not cleared after last item");

    a_begin_is_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_field_begin) |-> (o_byte_kind == KIND_FIELD_HDR))
        else $error("field begin on a byte that is not a field header");

    a_finish_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_field_finish && o_byte_kind == KIND_DATA)
        |-> (o_field_offset == o_field_length - 16'd1))
        else $error("field finish at wrong offset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");

endmodule

`default_nettype wire

FILE: tb/tlvcp_tb_pkg.sv
package tlvcp_tb_pkg;

    import tlvcp_pkg::*;

    // Labels the block attaches to one container byte
    typedef struct packed {
        t_kind       kind;
        logic [15:0] tag;
        logic [15:0] len;
        logic [15:0] off;
        logic        beg;
        logic        fin;
        logic [7:0]  data;
        logic        done;
        t_status     status;
    } byte_label_t;

    // Reflected CRC-32, one byte folded in LSB first
    function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        repeat (8) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: tb/tlv_label_checker.sv
module tlv_label_checker
    import tlvcp_pkg::*;
    import tlvcp_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_byte_kind,
    input  logic [15:0] i_field_tag,
    input  logic [15:0] i_field_length,
    input  logic [15:0] i_field_offset,
    input  logic        i_field_begin,
    input  logic        i_field_finish,
    input  logic [7:0]  i_data_byte,
    input  logic        i_done_res,
    input  logic [3:0]  i_status,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int PRINT_CAP = 60;

    // Parser state as the block should hold it
    logic [15:0]      exp_domain;
    logic [CNT_W-1:0] byte_cnt;
    logic [31:0]      hdr_shift;
    logic [31:0]      size_decl;
    logic [31:0]      crc_stored;
    logic [31:0]      crc_run;
    t_phase           phase;
    logic [1:0]       fh_idx;
    logic [15:0]      cur_tag;
    logic [15:0]      cur_len;
    logic [15:0]      data_left;
    t_status          first_err;

    byte_label_t      expected_labels[$];
    int               fails = 0;
    int               n_results = 0;

    function automatic void clear_stream();
        byte_cnt   = '0;
        hdr_shift  = '0;
        size_decl  = '0;
        crc_stored = '0;
        crc_run    = CRC_INIT;
        phase      = PH_AWAIT;
        fh_idx     = FH_TAG_LO;
        cur_tag    = '0;
        cur_len    = '0;
        data_left  = '0;
        first_err  = ST_OK;
    endfunction

    // Only the first error of a container is kept
    function automatic void note_fault(input t_status code);
        if (first_err == ST_OK) begin
            first_err = code;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (fails < PRINT_CAP) begin
            $display("[label_check] %0t: %s", $realtime, msg);
        end
        fails++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            report_mismatch($sformatf("result %0d %s: expected %0h, got %0h",
                                      n_results, name, want, got));
        end
    endtask

    // Work out the labels of one accepted byte and advance the parser state
    task automatic label_byte(input logic [7:0] b, input logic last, output byte_label_t r);
        logic [CNT_W-1:0] pos;
        pos      = byte_cnt;
        r        = '0;
        r.data   = b;
        r.done   = last;

        if (pos < HDR_BYTES) begin
            // container header, shifted in little-endian
            r.kind    = KIND_CONT_HDR;
            hdr_shift = {b, hdr_shift[31:8]};
            if (pos == POS_MAGIC_END && hdr_shift != MAGIC_WORD) begin
                note_fault(ST_MAGIC);
            end
            if (pos == POS_VERDOM_END) begin
                if (hdr_shift[15:0] != 16'd1) begin
                    note_fault(ST_VERSION);
                end else if (hdr_shift[31:16] != exp_domain) begin
                    note_fault(ST_DOMAIN);
                end
            end
            if (pos == POS_SIZE_END) begin
                size_decl = hdr_shift;
            end
            if (pos == POS_CHECK_END) begin
                crc_stored = hdr_shift;
            end
        end else begin
            crc_run = crc_fold_byte(crc_run, b);
            case (phase)
                PH_IGNORE: begin
                    r.kind = KIND_IGNORED;
                end
                PH_AWAIT: begin
                    // field header: tag then length, both little-endian
                    r.kind = KIND_FIELD_HDR;
                    case (fh_idx)
                        FH_TAG_LO: cur_tag = {8'h00, b};
                        FH_TAG_HI: cur_tag[15:8] = b;
                        FH_LEN_LO: cur_len = {8'h00, b};
                        default:   cur_len[15:8] = b;
                    endcase
                    if (fh_idx == FH_LEN_HI) begin
                        fh_idx = FH_TAG_LO;
                        if (cur_tag == 16'h0000) begin
                            phase = PH_IGNORE;
                            note_fault(ST_ZERO_TAG);
                        end else begin
                            r.tag = cur_tag;
                            r.len = cur_len;
                            r.beg = 1'b1;
                            if (cur_len == 16'h0000) begin
                                r.fin = 1'b1;
                            end else begin
                                phase     = PH_DATA;
                                data_left = cur_len;
                            end
                        end
                    end else begin
                        fh_idx = fh_idx + 2'd1;
                    end
                end
                default: begin
                    r.kind    = KIND_DATA;
                    r.tag     = cur_tag;
                    r.len     = cur_len;
                    r.off     = cur_len - data_left;
                    data_left = data_left - 16'd1;
                    if (data_left == 16'h0000) begin
                        r.fin = 1'b1;
                        phase = PH_AWAIT;
                    end
                end
            endcase
        end

        // byte count saturates one above the largest container
        if (byte_cnt <= MAX_CONTAINER_BYTES) begin
            byte_cnt = byte_cnt + 1'b1;
        end

        r.status = first_err;
        if (last) begin
            if (pos >= HDR_BYTES) begin
                if (phase == PH_AWAIT && fh_idx != FH_TAG_LO) begin
                    note_fault(ST_TRUNC_HDR);
                end else if (phase == PH_DATA) begin
                    note_fault(ST_OVERRUN);
                end
            end
            // verdict in priority order
            if (byte_cnt < HDR_BYTES) begin
                r.status = ST_SHORT;
            end else if (byte_cnt > MAX_CONTAINER_BYTES) begin
                r.status = ST_TOO_LARGE;
            end else if (first_err == ST_MAGIC || first_err == ST_VERSION ||
                         first_err == ST_DOMAIN) begin
                r.status = first_err;
            end else if (size_decl != 32'(byte_cnt) - HDR_BYTES) begin
                r.status = ST_SIZE;
            end else if (~crc_run != crc_stored) begin
                r.status = ST_CRC;
            end else begin
                r.status = first_err;
            end
            clear_stream();
        end
    endtask

    // Watch both channels and the register port
    always @(posedge i_clk) begin : watch
        byte_label_t want;
        if (!i_rst_n) begin
            exp_domain = '0;
            clear_stream();
            expected_labels.delete();
        end else begin
            if (i_cfg_we) begin
                exp_domain = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_labels.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no label pending",
                                              n_results));
                end else begin
                    want = expected_labels.pop_front();
                    check_field("byte_kind",    want.kind,   i_byte_kind);
                    check_field("field_tag",    want.tag,    i_field_tag);
                    check_field("field_length", want.len,    i_field_length);
                    check_field("field_offset", want.off,    i_field_offset);
                    check_field("field_begin",  want.beg,    i_field_begin);
                    check_field("field_finish", want.fin,    i_field_finish);
                    check_field("data_byte",    want.data,   i_data_byte);
                    check_field("done_res",     want.done,   i_done_res);
                    check_field("status",       want.status, i_status);
                end
                n_results++;
            end
            if (i_in_valid && !i_in_stall) begin
                label_byte(i_in_byte, i_in_last, want);
                expected_labels.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_labels.size();
    end

endmodule

FILE: tb/tb.sv
module tb;

    import tlvcp_pkg::*;
    import tlvcp_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int SETTLE       = 4;

    typedef enum int {
        SH_GOOD,
        SH_BAD_MAGIC,
        SH_BAD_VERSION,
        SH_BAD_DOMAIN,
        SH_BAD_SIZE,
        SH_BAD_CRC,
        SH_TRUNC_HDR,
        SH_OVERRUN,
        SH_ZERO_TAG,
        SH_SHORT,
        SH_NOISE
    } frame_shape_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_byte   = '0;
    logic        in_last   = 1'b0;
    logic        out_stall = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [1:0]  byte_kind;
    logic [15:0] field_tag;
    logic [15:0] field_length;
    logic [15:0] field_offset;
    logic        field_begin;
    logic        field_finish;
    logic [7:0]  data_byte;
    logic        done_res;
    logic [3:0]  status;

    int          fail_count;
    int          pending;

    // calm, hold_req and holding are shared between stimulus and the stall generator
    bit          calm      = 1'b0;
    bit          hold_req  = 1'b0;
    bit          holding   = 1'b0;
    logic [15:0] cur_domain = '0;
    logic [7:0]  frame_q[$];
    int          items_sent = 0;

    tlv_container_checker_parser_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .i_in_last      (in_last),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_byte_kind    (byte_kind),
        .o_field_tag    (field_tag),
        .o_field_length (field_length),
        .o_field_offset (field_offset),
        .o_field_begin  (field_begin),
        .o_field_finish (field_finish),
        .o_data_byte    (data_byte),
        .o_done_res     (done_res),
        .o_status       (status)
    );

    tlv_label_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .i_in_last      (in_last),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_byte_kind    (byte_kind),
        .i_field_tag    (field_tag),
        .i_field_length (field_length),
        .i_field_offset (field_offset),
        .i_field_begin  (field_begin),
        .i_field_finish (field_finish),
        .i_data_byte    (data_byte),
        .i_done_res     (done_res),
        .i_status       (status),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Mostly no gap, some short, the odd long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_tag();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 16'hFFFF;
        end else if (r == 1) begin
            return 16'h0001;
        end
        return 16'($urandom_range(1, 65535));
    endfunction

    function automatic logic [15:0] pick_len(input int max_len);
        if ($urandom_range(0, 99) < 15) begin
            return 16'h0000;
        end
        return 16'($urandom_range(1, max_len));
    endfunction

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) begin
            frame_q.push_back(v[8*i +: 8]);
        end
    endtask

    task automatic add_field(input logic [15:0] tag, input logic [15:0] len, input int n_data);
        put_le({16'd0, tag}, 2);
        put_le({16'd0, len}, 2);
        repeat (n_data) frame_q.push_back(8'($urandom));
    endtask

    // Offer every byte of frame_q, the final one flagged last
    task automatic send_frame();
        int gap;
        for (int i = 0; i < frame_q.size(); i++) begin
            gap = pick_gap();
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_byte  <= frame_q[i];
            in_last  <= (i == frame_q.size() - 1);
            @(posedge clk);
            while (in_stall) @(posedge clk);
            items_sent++;
        end
    endtask

    // Build one container of the given shape and send it
    task automatic run_frame(input frame_shape_t shape, input int n_fields, input int max_len);
        logic [31:0]  magic;
        logic [31:0]  crc;
        logic [31:0]  size_v;
        logic [15:0]  ver;
        logic [15:0]  dom;
        logic [15:0]  len_v;
        logic [127:0] hdr;
        frame_q.delete();
        if (shape == SH_SHORT || shape == SH_NOISE) begin
            // raw bytes, under the header length or at least as long as it
            if (shape == SH_SHORT) begin
                repeat ($urandom_range(1, HDR_BYTES - 1)) frame_q.push_back(8'($urandom));
            end else begin
                repeat ($urandom_range(HDR_BYTES, 48)) frame_q.push_back(8'($urandom));
            end
        end else begin
            repeat (HDR_BYTES) frame_q.push_back(8'h00);
            for (int f = 0; f < n_fields; f++) begin
                len_v = pick_len(max_len);
                add_field(pick_tag(), len_v, len_v);
            end
            // payload-level faults, with size and CRC kept consistent
            case (shape)
                SH_TRUNC_HDR: begin
                    repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
                end
                SH_OVERRUN: begin
                    len_v = 16'($urandom_range(2, max_len + 2));
                    add_field(pick_tag(), len_v, $urandom_range(0, len_v - 1));
                end
                SH_ZERO_TAG: begin
                    add_field(16'h0000, 16'($urandom), 0);
                    repeat ($urandom_range(0, 12)) frame_q.push_back(8'($urandom));
                end
                default: ;
            endcase
            crc = CRC_INIT;
            for (int i = HDR_BYTES; i < frame_q.size(); i++) begin
                crc = crc_fold_byte(crc, frame_q[i]);
            end
            crc    = ~crc;
            size_v = frame_q.size() - HDR_BYTES;
            magic  = MAGIC_WORD;
            ver    = 16'd1;
            dom    = cur_domain;
            // header faults: a single flipped bit or a wrong value
            case (shape)
                SH_BAD_MAGIC:   magic = magic ^ (32'd1 << $urandom_range(0, 31));
                SH_BAD_VERSION: begin
                    ver = 16'($urandom);
                    if (ver == 16'd1) begin
                        ver = 16'd0;
                    end
                end
                SH_BAD_DOMAIN:  dom = dom ^ 16'($urandom_range(1, 65535));
                SH_BAD_SIZE:    size_v = size_v ^ (32'd1 << $urandom_range(0, 31));
                SH_BAD_CRC:     crc = crc ^ (32'd1 << $urandom_range(0, 31));
                default: ;
            endcase
            hdr = {crc, size_v, dom, ver, magic};
            for (int i = 0; i < HDR_BYTES; i++) begin
                frame_q[i] = hdr[8*i +: 8];
            end
        end
        send_frame();
    endtask

    // Stop offering and wait until every result has been taken
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_domain(input logic [15:0] d);
        drain_block();
        repeat (SETTLE) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= d;
        @(posedge clk);
        cfg_we     <= 1'b0;
        cur_domain  = d;
    endtask

    // Result-side stall: random bursts, one long hold on request
    initial begin : stall_gen
        int run;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                holding    = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req   = 1'b0;
                holding    = 1'b0;
                @(posedge clk);
            end else begin
                run = pick_gap();
                if (run > 0) begin
                    out_stall <= 1'b1;
                    repeat (run) @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Give up when nothing moves on either channel for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("[tlv_container_checker_parser_core] ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] domains[6];
        int          r;
        frame_shape_t shape;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset domain, every frame shape at least once
        run_frame(SH_GOOD, 0, 1);
        run_frame(SH_GOOD, 3, 3);
        run_frame(SH_SHORT, 0, 1);
        run_frame(SH_BAD_MAGIC, 2, 4);
        run_frame(SH_BAD_VERSION, 1, 2);
        run_frame(SH_BAD_DOMAIN, 1, 2);
        run_frame(SH_BAD_SIZE, 1, 3);
        run_frame(SH_BAD_CRC, 1, 3);
        run_frame(SH_TRUNC_HDR, 1, 2);
        run_frame(SH_OVERRUN, 0, 3);
        run_frame(SH_ZERO_TAG, 1, 2);
        run_frame(SH_NOISE, 0, 1);

        // top domain, then a header carrying a different one
        write_domain(16'hFFFF);
        run_frame(SH_GOOD, 2, 4);
        run_frame(SH_BAD_DOMAIN, 0, 1);

        // hold the result side while the sender keeps offering
        write_domain(16'($urandom));
        hold_req = 1'b1;
        wait (holding);
        run_frame(SH_GOOD, 4, 12);

        // random phases, each writing the next domain from a list of six in turn
        domains[0] = 16'h0001;
        domains[1] = 16'($urandom);
        domains[2] = 16'h8000;
        domains[3] = 16'h0000;
        domains[4] = 16'($urandom);
        domains[5] = 16'hFFFF;
        for (int ph = 0; items_sent < RANDOM_ITEMS; ph++) begin
            write_domain(domains[ph % 6]);
            repeat (8) begin
                calm = ($urandom_range(0, 99) < 15);
                r    = $urandom_range(0, 99);
                if (r < 55) begin
                    shape = SH_GOOD;
                end else begin
                    shape = frame_shape_t'($urandom_range(SH_BAD_MAGIC, SH_NOISE));
                end
                run_frame(shape, $urandom_range(0, 4),
                          ($urandom_range(0, 4) == 0) ? 40 : 8);
            end
            calm = 1'b0;
        end

        drain_block();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[tlv_container_checker_parser_core] OK");
        end else begin
            $display("[tlv_container_checker_parser_core] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tlvcp_pkg.sv
rtl/tlv_container_checker_parser_core.sv
tb/tlvcp_tb_pkg.sv
tb/tlv_label_checker.sv
tb/tb.sv
